/* rtl/sll_pkg.sv */
// Package for the static linked list engine: operation codes and field widths.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none
package sll_pkg;
    localparam int OP_W  = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [OP_W-1:0] OP_PRED   = 3'd6;
    localparam logic [OP_W-1:0] OP_SUCC   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        position_or_count;
    } rsp_t;
endpackage
`default_nettype wire

/* rtl/sll_req_if.sv */
// Request channel of the linked list engine: valid, ready and one request item.
// Depends on sll_pkg.
`default_nettype none
interface sll_req_if;
    logic                         valid;
    logic                         ready;
    logic [sll_pkg::OP_W-1:0]     opcode;
    logic [sll_pkg::POS_W-1:0]    position;
    logic signed [sll_pkg::VAL_W-1:0] value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface
`default_nettype wire

/* rtl/sll_rsp_if.sv */
// Response channel of the linked list engine: valid, ready and one result item.
// Depends on sll_pkg.
`default_nettype none
interface sll_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic signed [sll_pkg::VAL_W-1:0] value_out;
    logic [sll_pkg::POS_W-1:0]        position_or_count;

    modport source (output valid, ok, value_out, position_or_count, input ready);
    modport sink   (input valid, ok, value_out, position_or_count, output ready);
endinterface
`default_nettype wire

/* rtl/static_linked_list_engine.sv */
// Static linked list engine: an ordered list of signed values in a node store
// whose link memory also chains the free nodes. Depends on sll_pkg and the
// sll_req_if / sll_rsp_if channel interfaces.
// An item walks the chain one link read at a time: each node visited is read in S_RD
// and used in S_WALK; clear returns every list node to the free chain. Items run one
// at a time. After reset an initialisation pass over every node rebuilds the free
// chain before the first item is taken.
`default_nettype none
module static_linked_list_engine #(
    parameter int NODES = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    sll_req_if.sink    req,
    sll_rsp_if.source  rsp
);
    localparam int AW = $clog2(NODES);
    localparam int CW = AW + 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_FREE  = 4'd4;
    localparam logic [3:0] S_FREE2 = 4'd5;
    localparam logic [3:0] S_W1    = 4'd6;
    localparam logic [3:0] S_W2    = 4'd7;
    localparam logic [3:0] S_W3    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_NVAL  = 4'd10;

    localparam logic [AW-1:0] NIL  = '0;
    localparam logic [AW-1:0] HEAD = AW'(1);

    // Link and value memories with registered reads.
    logic [AW-1:0]                    link_mem [NODES];
    logic signed [sll_pkg::VAL_W-1:0] val_mem  [NODES];
    logic [AW-1:0]                    lrd_q;
    logic signed [sll_pkg::VAL_W-1:0] vrd_q;
    logic [AW-1:0] l_ra, l_wa, l_wd, v_ra;
    logic          l_we, v_we;
    logic signed [sll_pkg::VAL_W-1:0] v_wd;
    logic [AW-1:0] v_wa;

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            link_mem[l_wa] <= l_wd;
        end
        if (v_we)
        begin
            val_mem[v_wa] <= v_wd;
        end
        lrd_q <= link_mem[l_ra];
        vrd_q <= val_mem[v_ra];
    end

    logic [3:0]                       state_reg, state_next;
    logic [sll_pkg::OP_W-1:0]         op_reg, op_next;
    logic [sll_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic signed [sll_pkg::VAL_W-1:0] key_reg, key_next;
    logic [AW-1:0]                    p_reg, p_next, q_reg, q_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic signed [sll_pkg::VAL_W-1:0] prev_reg, prev_next;
    logic                             first_reg, first_next;
    logic                             ok_reg, ok_next;
    logic signed [sll_pkg::VAL_W-1:0] vo_reg, vo_next;
    logic [sll_pkg::POS_W-1:0]        pc_reg, pc_next;
    logic                             hit;

    assign req.ready             = (state_reg == S_IDLE);
    assign rsp.valid             = (state_reg == S_OUT);
    assign rsp.ok                = ok_reg;
    assign rsp.value_out         = vo_reg;
    assign rsp.position_or_count = pc_reg;

    assign hit = (vrd_q == key_reg);

    // Sequencer: every read goes out in one state, its data is used in the next.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; pos_next = pos_reg; key_next = key_reg;
        p_next = p_reg; q_next = q_reg; cnt_next = cnt_reg;
        prev_next = prev_reg; first_next = first_reg;
        ok_next = ok_reg; vo_next = vo_reg; pc_next = pc_reg;
        l_ra = p_reg; v_ra = p_reg;
        l_we = 1'b0; l_wa = p_reg; l_wd = NIL;
        v_we = 1'b0; v_wa = q_reg; v_wd = key_reg;
        unique case (state_reg)
            S_INIT:
            begin
                // Rebuild the free chain 0 -> 2 -> ... -> NODES-1, list empty.
                l_we = 1'b1;
                l_wa = cnt_reg[AW-1:0];
                if (cnt_reg[AW-1:0] == NIL)
                    l_wd = (NODES > 2) ? AW'(2) : NIL;
                else if (cnt_reg[AW-1:0] == HEAD || cnt_reg == CW'(NODES - 1))
                    l_wd = NIL;
                else
                    l_wd = cnt_reg[AW-1:0] + AW'(1);
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NODES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.opcode; pos_next = req.position; key_next = req.value;
                    ok_next = 1'b0; vo_next = '0; pc_next = '0;
                    cnt_next = '0; first_next = 1'b1;
                    p_next = HEAD;
                    if ((req.opcode == sll_pkg::OP_INSERT || req.opcode == sll_pkg::OP_DELETE
                         || req.opcode == sll_pkg::OP_GET) && req.position == '0)
                        state_next = S_OUT;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                // Read link and value of p.
                l_ra = p_reg; v_ra = p_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // lrd_q = link(p); vrd_q = value(p) (p is a list node unless head).
                case (op_reg)
                    sll_pkg::OP_INSERT:
                    begin
                        if (cnt_reg == CW'(pos_reg - 9'd1))
                        begin
                            q_next = lrd_q;       // successor of p
                            l_ra = NIL;
                            state_next = S_FREE;
                        end
                        else if (lrd_q == NIL)
                            state_next = S_OUT;
                        else
                        begin
                            p_next = lrd_q; cnt_next = cnt_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    sll_pkg::OP_DELETE:
                    begin
                        if (lrd_q == NIL)
                            state_next = S_OUT;
                        else if (cnt_reg == CW'(pos_reg - 9'd1))
                        begin
                            q_next = lrd_q;
                            l_ra = lrd_q; v_ra = lrd_q;
                            state_next = S_FREE;
                        end
                        else
                        begin
                            p_next = lrd_q; cnt_next = cnt_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    sll_pkg::OP_GET:
                    begin
                        if (lrd_q == NIL)
                            state_next = S_OUT;
                        else if (cnt_reg == CW'(pos_reg - 9'd1))
                        begin
                            v_ra = lrd_q; state_next = S_NVAL;
                        end
                        else
                        begin
                            p_next = lrd_q; cnt_next = cnt_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    sll_pkg::OP_LENGTH:
                    begin
                        if (lrd_q == NIL)
                        begin
                            ok_next = 1'b1;
                            pc_next = sll_pkg::POS_W'(cnt_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            p_next = lrd_q; cnt_next = cnt_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    sll_pkg::OP_CLEAR:
                    begin
                        // Push each list node onto the free chain head.
                        if (p_reg == HEAD)
                        begin
                            if (lrd_q == NIL)
                            begin
                                ok_next = 1'b1; state_next = S_OUT;
                            end
                            else
                            begin
                                // Detach the list from the head, then visit its first node.
                                l_we = 1'b1; l_wa = HEAD; l_wd = NIL;
                                p_next = lrd_q; state_next = S_RD;
                            end
                        end
                        else
                        begin
                            q_next = lrd_q;   // next list node
                            l_ra = NIL; state_next = S_FREE;
                        end
                    end
                    default:
                    begin
                        // Locate, predecessor, successor scan by value.
                        if (p_reg == HEAD)
                        begin
                            if (lrd_q == NIL)
                                state_next = S_OUT;
                            else
                            begin
                                p_next = lrd_q; cnt_next = CW'(1); state_next = S_RD;
                            end
                        end
                        else if (hit)
                        begin
                            if (op_reg == sll_pkg::OP_LOCATE)
                            begin
                                ok_next = 1'b1; pc_next = sll_pkg::POS_W'(cnt_reg);
                                state_next = S_OUT;
                            end
                            else if (op_reg == sll_pkg::OP_PRED)
                            begin
                                ok_next = !first_reg; vo_next = first_reg ? '0 : prev_reg;
                                state_next = S_OUT;
                            end
                            else if (lrd_q == NIL)
                                state_next = S_OUT;
                            else
                            begin
                                v_ra = lrd_q; state_next = S_NVAL;
                            end
                        end
                        else if (lrd_q == NIL)
                            state_next = S_OUT;
                        else
                        begin
                            prev_next = vrd_q; first_next = 1'b0;
                            p_next = lrd_q; cnt_next = cnt_reg + CW'(1); state_next = S_RD;
                        end
                    end
                endcase
            end
            S_NVAL:
            begin
                // vrd_q holds the value of the wanted node.
                ok_next = 1'b1; vo_next = vrd_q; state_next = S_OUT;
            end
            S_FREE:
            begin
                // Insert/clear: lrd_q = free head. Delete: lrd_q = link(q), vrd_q = value(q).
                if (op_reg == sll_pkg::OP_DELETE)
                begin
                    vo_next = vrd_q;
                    l_we = 1'b1; l_wa = p_reg; l_wd = lrd_q;
                    l_ra = NIL; state_next = S_FREE2;
                end
                else if (op_reg == sll_pkg::OP_CLEAR)
                begin
                    l_we = 1'b1; l_wa = p_reg; l_wd = lrd_q;
                    state_next = S_W3;
                end
                else if (lrd_q == NIL)
                    state_next = S_OUT;
                else
                begin
                    cnt_next = CW'(lrd_q);  // new node, kept in cnt
                    v_we = 1'b1; v_wa = lrd_q; v_wd = key_reg;
                    l_ra = lrd_q; state_next = S_W1;
                end
            end
            S_FREE2:
            begin
                // Delete: release q to free head (lrd_q = old free head).
                l_we = 1'b1; l_wa = q_reg; l_wd = lrd_q;
                state_next = S_W3;
            end
            S_W1:
            begin
                // Insert: lrd_q = link(new); free head advances.
                l_we = 1'b1; l_wa = NIL; l_wd = lrd_q;
                state_next = S_W2;
            end
            S_W2:
            begin
                l_we = 1'b1; l_wa = cnt_reg[AW-1:0]; l_wd = q_reg;
                p_next = p_reg; q_next = cnt_reg[AW-1:0];
                state_next = S_W3;
            end
            S_W3:
            begin
                if (op_reg == sll_pkg::OP_CLEAR)
                begin
                    // Free head now p; continue with next list node.
                    l_we = 1'b1; l_wa = NIL; l_wd = p_reg;
                    if (q_reg == NIL)
                    begin
                        ok_next = 1'b1; state_next = S_OUT;
                    end
                    else
                    begin
                        p_next = q_reg; state_next = S_RD;
                    end
                end
                else if (op_reg == sll_pkg::OP_DELETE)
                begin
                    l_we = 1'b1; l_wa = NIL; l_wd = q_reg;
                    ok_next = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    // Insert: link p to the new node.
                    l_we = 1'b1; l_wa = p_reg; l_wd = q_reg;
                    ok_next = 1'b1; state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; pos_reg <= pos_next; key_reg <= key_next;
        p_reg <= p_next; q_reg <= q_next;
        prev_reg <= prev_next; first_reg <= first_next;
        ok_reg <= ok_next; vo_reg <= vo_next; pc_reg <= pc_next;
    end
endmodule
`default_nettype wire
